@@ hw/rtl/bounded_deque_with_indexed_read_defines.svh @@
// Assertion macros shared by the deque RTL.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef BOUNDED_DEQUE_WITH_INDEXED_READ_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_READ_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Package for the bounded deque: field widths, default sizes, operation and status codes.
// Has no dependencies; the interfaces and the top level use it.
`default_nettype none

package bdq_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ_AT    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// What travels from the access stage to the output register.
	typedef struct packed {
		logic                rd;
		status_t             status;
		logic [COUNT_W-1:0]  count;
	} stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdq_req_if.sv @@
// Request channel of the deque: valid/ready handshake with operation, word and position.
// Depends on bdq_pkg for the field widths.
`default_nettype none

interface bdq_req_if;
	logic                        valid;
	logic                        ready;
	logic [bdq_pkg::OP_W-1:0]    operation;
	logic [bdq_pkg::VALUE_W-1:0] entry_value;
	logic [bdq_pkg::POS_W-1:0]   position;

	modport source (output valid, output operation, output entry_value, output position,
		input ready);
	modport sink (input valid, input operation, input entry_value, input position,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bdq_rsp_if.sv @@
// Response channel of the deque: valid/ready handshake with word, status and count.
// Depends on bdq_pkg for the field widths.
`default_nettype none

interface bdq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bdq_pkg::VALUE_W-1:0]  result_value;
	logic [bdq_pkg::STATUS_W-1:0] status;
	logic [bdq_pkg::COUNT_W-1:0]  item_count;

	modport source (output valid, output result_value, output status, output item_count,
		input ready);
	modport sink (input valid, input result_value, input status, input item_count,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bounded_deque_with_indexed_read.sv @@
// Top level of the bounded deque with indexed read.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and the assertion macro header.

// The deque holds up to CAPACITY words in a ring buffer kept in one synchronous
// single-port memory, addressed from a front pointer and an element count held in
// flip-flops. Each request transaction pushes at either end, pops from either end or
// reads the word at a 1-based position from the front, and produces exactly one
// response transaction with the word, a status and the count after the operation.
// Every operation touches at most one memory entry, so the block sustains one
// transaction per cycle unless response back-pressure stalls it; a response passes the
// memory read register and then the output register. The pointer and count are
// updated at acceptance because the decision never depends on stored data, and a
// read that follows a write to the same entry sees the written word since the write
// lands before the read is accepted. The output register lets a new request be
// accepted while a finished response still waits. Memory contents are not cleared
// at reset: only entries inside the count are ever read, and each was written by a push.
`default_nettype none

`include "bounded_deque_with_indexed_read_defines.svh"

module bounded_deque_with_indexed_read #(
	parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	bdq_req_if.sink   request,
	bdq_rsp_if.source response
);

	localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW    = PW + 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;
	localparam int VW    = bdq_pkg::VALUE_W;
	localparam int OCW   = bdq_pkg::COUNT_W;

	// Ring buffer storage.
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_s1;

	// Control state.
	logic [PW-1:0]   front_q;
	logic [CW-1:0]   count_q;
	logic            valid_s1;
	bdq_pkg::stage_t info_s1;
	logic            out_valid_q;
	logic [VW-1:0]   out_value_q;
	bdq_pkg::status_t out_status_q;
	logic [OCW-1:0]  out_count_q;

	// Handshake.
	logic in_ready;
	logic in_acc;
	logic s1_move;

	// Decode results.
	bdq_pkg::op_t     op;
	logic [PW-1:0]    offset;
	logic [SW-1:0]    ring_sum;
	logic [PW-1:0]    ring_addr;
	logic [PW-1:0]    front_dec;
	logic [PW-1:0]    front_inc;
	logic             is_full;
	logic             is_empty;
	logic             pos_bad;
	logic             do_wr;
	logic             do_rd;
	logic [PW-1:0]    addr;
	logic [PW-1:0]    front_nx;
	logic [CW-1:0]    count_nx;
	bdq_pkg::status_t status_nx;

	assign op       = bdq_pkg::op_t'(request.operation);
	assign s1_move  = valid_s1 && (!out_valid_q || response.ready);
	assign in_ready = !valid_s1 || s1_move;
	assign in_acc   = request.valid && in_ready;
	assign request.ready = in_ready;

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign pos_bad  = (request.position == '0) ||
		(CMP_W'(request.position) > CMP_W'(count_q));

	assign front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	// Offset from the front for the operations that address relative to it.
	always_comb begin
		unique case (op)
			bdq_pkg::OP_PUSH_BACK: offset = PW'(count_q);
			bdq_pkg::OP_POP_BACK:  offset = PW'(count_q - 1'b1);
			bdq_pkg::OP_READ_AT:   offset = PW'(request.position - 1'b1);
			default:               offset = '0;
		endcase
	end

	// Both terms are below CAPACITY, so one conditional subtract wraps the sum.
	assign ring_sum  = SW'(front_q) + SW'(offset);
	assign ring_addr = (ring_sum >= SW'(CAPACITY)) ? PW'(ring_sum - SW'(CAPACITY))
		: PW'(ring_sum);

	always_comb begin
		do_wr     = 1'b0;
		do_rd     = 1'b0;
		addr      = ring_addr;
		front_nx  = front_q;
		count_nx  = count_q;
		status_nx = bdq_pkg::ST_OK;
		unique case (op)
			bdq_pkg::OP_PUSH_FRONT: begin
				if (is_full) begin
					status_nx = bdq_pkg::ST_FULL;
				end else begin
					do_wr    = 1'b1;
					addr     = front_dec;
					front_nx = front_dec;
					count_nx = count_q + 1'b1;
				end
			end
			bdq_pkg::OP_PUSH_BACK: begin
				if (is_full) begin
					status_nx = bdq_pkg::ST_FULL;
				end else begin
					do_wr    = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (is_empty) begin
					status_nx = bdq_pkg::ST_EMPTY;
				end else begin
					do_rd    = 1'b1;
					addr     = front_q;
					front_nx = front_inc;
					count_nx = count_q - 1'b1;
				end
			end
			bdq_pkg::OP_POP_BACK: begin
				if (is_empty) begin
					status_nx = bdq_pkg::ST_EMPTY;
				end else begin
					do_rd    = 1'b1;
					count_nx = count_q - 1'b1;
				end
			end
			bdq_pkg::OP_READ_AT: begin
				if (pos_bad) begin
					status_nx = bdq_pkg::ST_RANGE;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
				// Unused operation codes leave the state alone and answer ok.
			end
		endcase
	end

	// Single-port memory: at most one write or one read per accepted transaction.
	// The read data register holds while the access stage is stalled, because
	// no new request is accepted then.
	always_ff @(posedge clk) begin
		if (in_acc && do_wr) begin
			mem[addr] <= DATA_WIDTH'(request.entry_value);
		end
		if (in_acc && do_rd) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				front_q <= front_nx;
				count_q <= count_nx;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			info_s1.rd     <= do_rd;
			info_s1.status <= status_nx;
			info_s1.count  <= OCW'(count_nx);
		end
		if (s1_move) begin
			out_value_q  <= info_s1.rd ? VW'(rd_data_s1) : '0;
			out_status_q <= info_s1.status;
			out_count_q  <= info_s1.count;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.result_value = out_value_q;
	assign response.status       = out_status_q;
	assign response.item_count   = out_count_q;

	// The count never exceeds the capacity.
	`BDQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		count_q <= CW'(CAPACITY), "count above capacity")

	// A successful pop removes exactly one element.
	`BDQ_ASSERT_NEXT(a_pop_dec, clk, arst_n,
		in_acc && !is_empty && (op == bdq_pkg::OP_POP_FRONT || op == bdq_pkg::OP_POP_BACK),
		count_q == $past(count_q) - 1'b1, "pop did not decrement count")

	// A response that is not ok carries a zero word.
	`BDQ_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid_q && out_status_q != bdq_pkg::ST_OK,
		out_value_q == '0, "nonzero word with error status")

endmodule

`default_nettype wire
